### rtl/sseext_pkg.sv
`default_nettype none
package sseext_pkg;

  localparam logic [7:0] ChLf    = 8'h0A;
  localparam logic [7:0] ChCr    = 8'h0D;
  localparam logic [7:0] ChSpace = 8'h20;
  localparam logic [7:0] ChColon = 8'h3A;
  localparam logic [7:0] ChD     = 8'h64;
  localparam logic [7:0] ChA     = 8'h61;
  localparam logic [7:0] ChT     = 8'h74;

  localparam int QDepth = 4;
  localparam int QIdxW  = $clog2(QDepth);
  localparam int QCntW  = $clog2(QDepth + 1);

  // One result beat.
  typedef struct packed {
    logic [7:0] byte_val;
    logic       has_byte;
    logic       event_end;
  } res_t;

  // Up to two result beats caused by one accepted byte, packed from entry 0.
  typedef struct packed {
    logic [1:0] cnt;
    res_t       ent0;
    res_t       ent1;
  } push_t;

  // Queue status seen by the input handshake and the back.
  typedef struct packed {
    logic [QCntW-1:0] count;
    logic             room2;
    logic             not_empty;
  } qstat_t;

endpackage
`default_nettype wire

### rtl/sseext_front.sv
`default_nettype none
module sseext_front
  import sseext_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       accept,
  input  wire logic [7:0] data_byte,
  output push_t           push
);

  typedef enum logic [7:0] {
    PH_START   = 8'b0000_0001,
    PH_D1      = 8'b0000_0010,
    PH_D2      = 8'b0000_0100,
    PH_D3      = 8'b0000_1000,
    PH_D4      = 8'b0001_0000,
    PH_COLON   = 8'b0010_0000,
    PH_PAYLOAD = 8'b0100_0000,
    PH_IGNORE  = 8'b1000_0000
  } phase_t;

  typedef struct packed {
    phase_t phase;
    logic   has_data;
    logic   emit;
    res_t   res;
  } lb_t;

  phase_t line_phase, line_phase_next;
  logic   cr_held, cr_held_next;
  logic   event_has_data, event_has_data_next;

  // One content byte of the current line.
  function automatic lb_t line_byte(phase_t ph, logic hd, logic [7:0] b);
    lb_t r;
    r.phase    = PH_IGNORE;
    r.has_data = hd;
    r.emit     = 1'b0;
    r.res      = '{byte_val: b, has_byte: 1'b1, event_end: 1'b0};
    case (ph)
      PH_START: r.phase = (b == ChD) ? PH_D1 : PH_IGNORE;
      PH_D1:    r.phase = (b == ChA) ? PH_D2 : PH_IGNORE;
      PH_D2:    r.phase = (b == ChT) ? PH_D3 : PH_IGNORE;
      PH_D3:    r.phase = (b == ChA) ? PH_D4 : PH_IGNORE;
      PH_D4: begin
        if (b == ChColon) begin
          // A later data line in the same event is preceded by an LF.
          r.emit         = hd;
          r.res.byte_val = ChLf;
          r.has_data     = 1'b1;
          r.phase        = PH_COLON;
        end
      end
      PH_COLON: begin
        r.phase = PH_PAYLOAD;
        r.emit  = (b != ChSpace);
      end
      PH_PAYLOAD: begin
        r.phase = PH_PAYLOAD;
        r.emit  = 1'b1;
      end
      default: r.phase = PH_IGNORE;
    endcase
    return r;
  endfunction

  lb_t first, second;

  always_comb begin
    first  = line_byte(line_phase, event_has_data, ChCr);
    if (!cr_held) begin
      first.phase    = line_phase;
      first.has_data = event_has_data;
      first.emit     = 1'b0;
    end
    second = line_byte(first.phase, first.has_data, data_byte);

    line_phase_next     = line_phase;
    event_has_data_next = event_has_data;
    cr_held_next        = cr_held;
    push.cnt            = 2'd0;
    push.ent0           = first.res;
    push.ent1           = second.res;

    if (data_byte == ChLf) begin
      // A held CR before LF is dropped; an empty line closes the event.
      cr_held_next    = 1'b0;
      line_phase_next = PH_START;
      push.ent0       = '{byte_val: 8'd0, has_byte: 1'b0, event_end: 1'b1};
      if (line_phase == PH_START) begin
        push.cnt            = {1'b0, event_has_data};
        event_has_data_next = 1'b0;
      end
    end else if (data_byte == ChCr) begin
      cr_held_next        = 1'b1;
      line_phase_next     = first.phase;
      event_has_data_next = first.has_data;
      push.cnt            = {1'b0, first.emit};
    end else begin
      cr_held_next        = 1'b0;
      line_phase_next     = second.phase;
      event_has_data_next = second.has_data;
      push.cnt            = 2'(first.emit) + 2'(second.emit);
      if (!first.emit) begin
        push.ent0 = second.res;
      end
    end
    if (!accept) begin
      push.cnt = 2'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      line_phase     <= PH_START;
      cr_held        <= 1'b0;
      event_has_data <= 1'b0;
    end else if (accept) begin
      line_phase     <= line_phase_next;
      cr_held        <= cr_held_next;
      event_has_data <= event_has_data_next;
    end
  end

endmodule
`default_nettype wire

### rtl/sseext_queue.sv
`default_nettype none
module sseext_queue
  import sseext_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire push_t push,
  input  wire logic  pop,
  output res_t       head,
  output qstat_t     stat
);

  res_t             mem [QDepth];
  logic [QIdxW-1:0] rd_ptr, wr_ptr;
  logic [QCntW-1:0] count, count_next;
  logic [QIdxW-1:0] wr_ptr1;

  assign wr_ptr1 = wr_ptr + QIdxW'(1);
  assign head    = mem[rd_ptr];

  assign stat.count     = count;
  assign stat.room2     = (count <= QCntW'(QDepth - 2));
  assign stat.not_empty = (count != '0);

  assign count_next = count + QCntW'(push.cnt) - QCntW'(pop);

  always_ff @(posedge clk) begin
    if (push.cnt != 2'd0) begin
      mem[wr_ptr] <= push.ent0;
    end
    if (push.cnt == 2'd2) begin
      mem[wr_ptr1] <= push.ent1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_ptr <= '0;
      wr_ptr <= '0;
      count  <= '0;
    end else begin
      rd_ptr <= rd_ptr + QIdxW'(pop);
      wr_ptr <= wr_ptr + QIdxW'(push.cnt);
      count  <= count_next;
    end
  end

endmodule
`default_nettype wire

### rtl/sseext_back.sv
`default_nettype none
module sseext_back
  import sseext_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire res_t        head,
  input  wire qstat_t      stat,
  output logic             pop,
  output logic             result_valid,
  input  wire logic        result_stall,
  output logic [7:0]       out_byte,
  output logic             has_byte,
  output logic             event_end
);

  res_t hold;

  // The output register reloads whenever the queue holds a beat and the register is empty or its beat leaves.
  assign pop = stat.not_empty && (!result_valid || !result_stall);

  assign out_byte  = hold.byte_val;
  assign has_byte  = hold.has_byte;
  assign event_end = hold.event_end;

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (!result_valid || !result_stall) begin
      result_valid <= stat.not_empty;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      hold <= head;
    end
  end

endmodule
`default_nettype wire

### rtl/sse_event_data_extractor.sv
// Channel  Direction  Handshake                   Payload
// item     in         item_valid / item_stall     data_byte
// result   out        result_valid / result_stall out_byte, has_byte, event_end
//
// One byte is taken per cycle while item_stall is low; each yields zero, one or two result
// beats. A byte is held off only while the four-entry result queue has fewer than two
// free entries, so sustained rate is one byte per cycle when results drain.
// A byte's first result beat passes through the queue and then the output register.
// Reset (rst, synchronous) returns the line parser to start of line and empties the queue.
`default_nettype none
module sse_event_data_extractor
  import sseext_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       item_valid,
  output logic            item_stall,
  input  wire logic [7:0] data_byte,
  output logic            result_valid,
  input  wire logic       result_stall,
  output logic [7:0]      out_byte,
  output logic            has_byte,
  output logic            event_end
);

  push_t  push;
  qstat_t stat;
  res_t   head;
  logic   pop;
  logic   accept;

  assign item_stall = !stat.room2;
  assign accept     = item_valid && !item_stall;

  sseext_front u_front (
    .clk       (clk),
    .rst       (rst),
    .accept    (accept),
    .data_byte (data_byte),
    .push      (push)
  );

  sseext_queue u_queue (
    .clk  (clk),
    .rst  (rst),
    .push (push),
    .pop  (pop),
    .head (head),
    .stat (stat)
  );

  sseext_back u_back (
    .clk          (clk),
    .rst          (rst),
    .head         (head),
    .stat         (stat),
    .pop          (pop),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .out_byte     (out_byte),
    .has_byte     (has_byte),
    .event_end    (event_end)
  );

`ifndef NO_ASSERTIONS
  a_qcount_max: assert property (@(posedge clk) disable iff (rst)
    stat.count <= QCntW'(QDepth))
    else $error("result queue over capacity");

  a_end_no_byte: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> !(has_byte && event_end) && (has_byte || out_byte == 8'd0))
    else $error("malformed result beat");

  a_push_needs_room: assert property (@(posedge clk) disable iff (rst)
    (push.cnt != 2'd0) |-> stat.room2)
    else $error("push into full queue");

  a_pop_when_data: assert property (@(posedge clk) disable iff (rst)
    pop |-> stat.not_empty)
    else $error("pop from empty queue");
`endif

endmodule
`default_nettype wire
